[rtl/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants of the message pool FIFO
// Sizes of the slot pool and index queue, request and result layouts,
// status and opcode codes, and the payload byte mask.
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

   localparam int POOL_SLOTS  = 16;
   localparam int QUEUE_DEPTH = 16;

   localparam int SLOT_W  = $clog2(POOL_SLOTS);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int USED_W  = $clog2(POOL_SLOTS + 1);
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] MAX_LEN = 4'd8;

   localparam logic OP_PUBLISH = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   typedef enum logic [2:0] {
      STATUS_STORED    = 3'd0,
      STATUS_EXHAUSTED = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_DELIVERED = 3'd4
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] msg_id;
      logic [63:0] payload;
      logic [3:0]  byte_count;
      logic [63:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_id;
      logic [63:0] out_payload;
      logic [3:0]  out_length;
      logic [63:0] out_time;
      logic [4:0]  pool_used;
      logic [4:0]  queue_level;
   } rsp_type;

   // Result of the lowest-free-slot search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } alloc_type;

   // Keep the low len bytes of data, clear the rest (len already at most 8)
   function automatic logic [63:0] keep_bytes(logic [63:0] data, logic [3:0] len);
      logic [63:0] result;
      result = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len) begin
            result[8*i +: 8] = data[8*i +: 8];
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/mpf_slot_alloc.sv]
// ----------------------------------------------------------------------------
// mpf_slot_alloc: lowest free slot search
// Priority encoder over the slot free map; reports whether any slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_slot_alloc (
   input  wire logic [mpf_pkg::POOL_SLOTS-1:0] free_map,
   output mpf_pkg::alloc_type                   alloc
);
   import mpf_pkg::*;

   always_comb begin
      alloc = '0;
      // scan downward so the lowest free slot wins
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (free_map[i]) begin
            alloc.found = 1'b1;
            alloc.index = SLOT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/message_pool_fifo.sv]
// ----------------------------------------------------------------------------
// message_pool_fifo: message slot pool with a FIFO of slot indices
// Pipeline: a request taken at a clock edge is registered in the input register;
//   its result is worked out from it and captured in the result register, which
//   drives the result strobe and the result data.
// Throughput: one request per cycle; busy stays low.
// Reset: synchronous; all slots free, queue empty, no result pending.
//   Message stores hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module message_pool_fifo (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire mpf_pkg::req_type req_data,
   output logic                 rsp_valid,
   output mpf_pkg::rsp_type     rsp_data
);
   import mpf_pkg::*;

   // Input register
   logic    req_valid_ff;
   req_type req_ff;

   // Pool and queue control state
   logic [POOL_SLOTS-1:0] free_map_ff, free_map_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;

   // Per-slot message stores and the index queue
   logic [31:0]       id_store_ff      [POOL_SLOTS];
   logic [63:0]       payload_store_ff [POOL_SLOTS];
   logic [3:0]        length_store_ff  [POOL_SLOTS];
   logic [63:0]       time_store_ff    [POOL_SLOTS];
   logic [SLOT_W-1:0] index_fifo_ff    [QUEUE_DEPTH];

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   alloc_type         alloc;
   logic              store_we;
   logic [SLOT_W-1:0] pop_slot;
   logic [3:0]        clipped_len;

   // The block never stalls the requester
   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mpf_slot_alloc u_slot_alloc (
      .free_map (free_map_ff),
      .alloc    (alloc)
   );

   assign pop_slot    = index_fifo_ff[head_ff];
   assign clipped_len = (req_ff.byte_count > MAX_LEN) ? MAX_LEN : req_ff.byte_count;

   // Work out the one result and the next state for the registered request
   always_comb begin
      free_map_in = free_map_ff;
      used_in     = used_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;
      store_we    = 1'b0;
      rsp_in      = '0;

      if (req_valid_ff) begin
         if (req_ff.opcode == OP_PUBLISH) begin
            if (!alloc.found) begin
               rsp_in.status = STATUS_EXHAUSTED;
            end else if (level_ff == LEVEL_W'(QUEUE_DEPTH)) begin
               // slot would be claimed and released at once: leave the pool as is
               rsp_in.status = STATUS_DROPPED;
            end else begin
               // claim the slot, store the message, push the index
               store_we                 = 1'b1;
               free_map_in[alloc.index] = 1'b0;
               used_in                  = used_ff + 1'b1;
               tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               level_in = level_ff + 1'b1;
               rsp_in.status            = STATUS_STORED;
            end
         end else begin
            if (level_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               // pop the oldest index, deliver its message, free the slot
               head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               level_in = level_ff - 1'b1;
               rsp_in.status      = STATUS_DELIVERED;
               rsp_in.out_id      = id_store_ff[pop_slot];
               rsp_in.out_payload = payload_store_ff[pop_slot];
               rsp_in.out_length  = length_store_ff[pop_slot];
               rsp_in.out_time    = time_store_ff[pop_slot];
               if (!free_map_ff[pop_slot]) begin
                  free_map_in[pop_slot] = 1'b1;
                  used_in               = used_ff - 1'b1;
               end
            end
         end
         rsp_in.pool_used   = 5'(used_in);
         rsp_in.queue_level = 5'(level_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_map_ff  <= '1;
         used_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         level_ff     <= '0;
      end else begin
         req_valid_ff <= start & ~busy;
         rsp_valid_ff <= req_valid_ff;
         free_map_ff  <= free_map_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         level_ff     <= level_in;
      end
   end

   // Payload registers: capture the request, hold the result
   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // Message stores and the index queue, written on a successful publish
   always_ff @(posedge clock) begin
      if (store_we) begin
         id_store_ff[alloc.index]      <= req_ff.msg_id;
         payload_store_ff[alloc.index] <= keep_bytes(req_ff.payload, clipped_len);
         length_store_ff[alloc.index]  <= clipped_len;
         time_store_ff[alloc.index]    <= req_ff.time_stamp;
         index_fifo_ff[tail_ff]        <= alloc.index;
      end
   end

endmodule

`default_nettype wire

[rtl/mpf_checker.sv]
// ----------------------------------------------------------------------------
// mpf_checker: port-level checks of the message pool FIFO
// Watches request transfers and result strobes on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire mpf_pkg::rsp_type rsp_data
);
   import mpf_pkg::*;

   // every accepted request gives exactly one result, after the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request transfer without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without request transfer");

   // occupancy never exceeds the pool and queue sizes, and the queue level never exceeds the pool use
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pool_used <= 5'(POOL_SLOTS))
                 && (rsp_data.queue_level <= 5'(QUEUE_DEPTH))
                 && (rsp_data.queue_level <= rsp_data.pool_used))
      else $error("occupancy out of range");

   // delivery fields are zero unless a message is delivered
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DELIVERED) |->
         (rsp_data.out_id == '0) && (rsp_data.out_payload == '0)
         && (rsp_data.out_length == '0) && (rsp_data.out_time == '0))
      else $error("delivery fields set without delivery");

   a_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_DELIVERED) |-> rsp_data.out_length <= MAX_LEN)
      else $error("delivered length above limit");

endmodule

bind message_pool_fifo mpf_checker u_mpf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
